// ----- hw/rtl/cce_pkg.sv -----
// ----------------------------------------------------------------------------
// cce_pkg
// Shared constants and controller-to-datapath types for the Chebyshev series
// evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package cce_pkg;

	localparam int MAX_TERMS_DEF  = 32;
	localparam int DATA_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF  = 30;

	localparam int GUARD_BITS = 8;
	localparam int IDX_BITS   = 5;
	localparam int NT_BITS    = 6;

	localparam logic [NT_BITS-1:0] NT_RESET = NT_BITS'(32);

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_EVAL = 1'b1;

	typedef struct packed {
		logic               start;
		logic               load_we;
		logic               mul_lo;
		logic               mul_hi;
		logic               round;
		logic               add;
		logic               last;
		logic [NT_BITS-1:0] idx;
	} cmd_t;

	typedef struct packed {
		logic out_busy;
	} sts_t;

endpackage

`default_nettype wire

// ----- hw/rtl/cce_ctrl.sv -----
// ----------------------------------------------------------------------------
// cce_ctrl
// Sequencer for the evaluator: holds the term count register, walks the
// coefficient index down and steps the datapath through each recurrence step.
// ----------------------------------------------------------------------------
`default_nettype none

module cce_ctrl #(
	parameter int MAX_TERMS = cce_pkg::MAX_TERMS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic                        opcode,
	input  wire logic                        cfg_we,
	input  wire logic [cce_pkg::NT_BITS-1:0] cfg_wdata,
	input  wire cce_pkg::sts_t               sts,
	output cce_pkg::cmd_t                    cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_LO   = 3'd1;
	localparam logic [2:0] S_HI   = 3'd2;
	localparam logic [2:0] S_RND  = 3'd3;
	localparam logic [2:0] S_ADD  = 3'd4;

	logic [2:0]                  state_q;
	logic [2:0]                  state_d;
	logic [cce_pkg::NT_BITS-1:0] num_terms_q;
	logic [cce_pkg::NT_BITS-1:0] k_q;
	logic [cce_pkg::NT_BITS-1:0] k_d;
	logic [cce_pkg::NT_BITS-1:0] n_eff;
	logic                        accept;
	logic                        last;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign last     = (k_q == '0);

	always_comb begin
		n_eff = num_terms_q;
		if (num_terms_q == '0) begin
			n_eff = cce_pkg::NT_BITS'(1);
		end else if (32'(num_terms_q) > MAX_TERMS) begin
			n_eff = cce_pkg::NT_BITS'(MAX_TERMS);
		end
	end

	always_comb begin
		state_d     = state_q;
		k_d         = k_q;
		cmd         = '0;
		cmd.last    = last;
		cmd.idx     = k_q;
		case (state_q)
			S_IDLE: begin
				if (accept && opcode == cce_pkg::OP_LOAD) begin
					cmd.load_we = 1'b1;
				end else if (accept && opcode == cce_pkg::OP_EVAL) begin
					cmd.start = 1'b1;
					k_d       = n_eff - cce_pkg::NT_BITS'(1);
					state_d   = S_LO;
				end
			end
			S_LO: begin
				cmd.mul_lo = 1'b1;
				state_d    = S_HI;
			end
			S_HI: begin
				cmd.mul_hi = 1'b1;
				state_d    = S_RND;
			end
			S_RND: begin
				cmd.round = 1'b1;
				state_d   = S_ADD;
			end
			S_ADD: begin
				if (!last) begin
					cmd.add = 1'b1;
					k_d     = k_q - cce_pkg::NT_BITS'(1);
					state_d = S_LO;
				end else if (!sts.out_busy) begin
					cmd.add = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			k_q         <= '0;
			num_terms_q <= cce_pkg::NT_RESET;
		end else begin
			state_q <= state_d;
			k_q     <= k_d;
			if (cfg_we) begin
				num_terms_q <= cfg_wdata;
			end
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/cce_dpath.sv -----
// ----------------------------------------------------------------------------
// cce_dpath
// Datapath of the evaluator: coefficient memory, split multiplier, rounding
// and saturation, recurrence registers and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cce_dpath #(
	parameter int MAX_TERMS  = cce_pkg::MAX_TERMS_DEF,
	parameter int DATA_WIDTH = cce_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = cce_pkg::FRAC_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire cce_pkg::cmd_t                cmd,
	output cce_pkg::sts_t                     sts,
	input  wire logic [cce_pkg::IDX_BITS-1:0] coeff_index,
	input  wire logic signed [DATA_WIDTH-1:0] coeff_value,
	input  wire logic signed [DATA_WIDTH-1:0] x_value,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic signed [DATA_WIDTH-1:0]      series_value,
	output logic                              saturated
);

	localparam int ACC  = DATA_WIDTH + cce_pkg::GUARD_BITS;
	localparam int LOW  = ACC / 2;
	localparam int HIW  = ACC - LOW;
	localparam int PW   = DATA_WIDTH + ACC;
	localparam int SW   = ACC + 2;
	localparam int AW   = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

	localparam logic signed [PW-1:0] HALF_FINAL = PW'(1) <<< (FRAC_BITS - 1);
	localparam logic signed [PW-1:0] HALF_STEP  = PW'(1) <<< (FRAC_BITS - 2);

	localparam logic signed [ACC-1:0] ACC_MAX = {1'b0, {(ACC-1){1'b1}}};
	localparam logic signed [ACC-1:0] ACC_MIN = {1'b1, {(ACC-1){1'b0}}};
	localparam logic signed [DATA_WIDTH-1:0] DW_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam logic signed [DATA_WIDTH-1:0] DW_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

	logic signed [DATA_WIDTH-1:0] mem [MAX_TERMS];

	logic signed [DATA_WIDTH-1:0]     x_q;
	logic signed [DATA_WIDTH-1:0]     c_q;
	logic signed [ACC-1:0]            b1_q;
	logic signed [ACC-1:0]            b2_q;
	logic signed [ACC-1:0]            t_q;
	logic signed [PW-1:0]             plo_q;
	logic signed [DATA_WIDTH+HIW-1:0] phi_q;
	logic                             sat_q;
	logic                             out_valid_q;
	logic signed [DATA_WIDTH-1:0]     result_q;
	logic                             result_sat_q;

	logic signed [DATA_WIDTH+LOW:0]   plo_c;
	logic signed [DATA_WIDTH+HIW-1:0] phi_c;
	logic                             neg;
	logic signed [PW-1:0]             bias;
	logic signed [PW-1:0]             p_sum;
	logic signed [PW-1:0]             q;
	logic                             q_ovf;
	logic signed [ACC-1:0]            t_c;
	logic signed [SW-1:0]             s_sum;
	logic                             acc_ovf;
	logic                             dw_ovf;
	logic signed [ACC-1:0]            b_c;
	logic signed [DATA_WIDTH-1:0]     y_c;

	assign plo_c = (DATA_WIDTH+LOW+1)'(x_q) *
		(DATA_WIDTH+LOW+1)'($signed({1'b0, b1_q[LOW-1:0]}));
	assign phi_c = (DATA_WIDTH+HIW)'(x_q) * (DATA_WIDTH+HIW)'($signed(b1_q[ACC-1:LOW]));
	assign neg   = x_q[DATA_WIDTH-1] ^ b1_q[ACC-1];
	assign bias  = (cmd.last ? HALF_FINAL : HALF_STEP) - $signed({{(PW-1){1'b0}}, neg});

	assign p_sum = $signed({phi_q, {LOW{1'b0}}}) + plo_q;
	assign q     = cmd.last ? (p_sum >>> FRAC_BITS) : (p_sum >>> (FRAC_BITS - 1));
	assign q_ovf = !((&q[PW-1:ACC-1]) || !(|q[PW-1:ACC-1]));
	assign t_c   = q_ovf ? (q[PW-1] ? ACC_MIN : ACC_MAX) : q[ACC-1:0];

	assign s_sum   = SW'(c_q) + SW'(t_q) - SW'(b2_q);
	assign acc_ovf = !((&s_sum[SW-1:ACC-1]) || !(|s_sum[SW-1:ACC-1]));
	assign dw_ovf  = !((&s_sum[SW-1:DATA_WIDTH-1]) || !(|s_sum[SW-1:DATA_WIDTH-1]));
	assign b_c     = acc_ovf ? (s_sum[SW-1] ? ACC_MIN : ACC_MAX) : s_sum[ACC-1:0];
	assign y_c     = dw_ovf ? (s_sum[SW-1] ? DW_MIN : DW_MAX) : s_sum[DATA_WIDTH-1:0];

	always_ff @(posedge clk) begin
		if (cmd.load_we && 32'(coeff_index) < MAX_TERMS) begin
			mem[AW'(coeff_index)] <= coeff_value;
		end
		if (cmd.mul_lo) begin
			c_q <= mem[AW'(cmd.idx)];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			x_q   <= x_value;
			b1_q  <= '0;
			b2_q  <= '0;
			sat_q <= 1'b0;
		end
		if (cmd.mul_lo) begin
			plo_q <= PW'(plo_c);
		end
		if (cmd.mul_hi) begin
			phi_q <= phi_c;
			plo_q <= plo_q + bias;
		end
		if (cmd.round) begin
			t_q   <= t_c;
			sat_q <= sat_q | q_ovf;
		end
		if (cmd.add && !cmd.last) begin
			b1_q  <= b_c;
			b2_q  <= b1_q;
			sat_q <= sat_q | acc_ovf;
		end
		if (cmd.add && cmd.last) begin
			result_q     <= y_c;
			result_sat_q <= sat_q | dw_ovf;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.add && cmd.last) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign sts.out_busy = out_valid_q && out_stall;
	assign out_valid    = out_valid_q;
	assign series_value = result_q;
	assign saturated    = result_sat_q;

endmodule

`default_nettype wire

// ----- hw/rtl/chebyshev_clenshaw_eval.sv -----
// ----------------------------------------------------------------------------
// chebyshev_clenshaw_eval
// Chebyshev series evaluator in signed fixed point using the Clenshaw
// recurrence, with a coefficient memory loaded through the input channel.
// ----------------------------------------------------------------------------
// A load beat (opcode 0) writes one coefficient into the memory in the cycle
// it is accepted and produces no result. An evaluate beat (opcode 1) runs the
// recurrence from the highest coefficient in use down to index zero and
// produces one result beat with the saturated Q2.30 value and a flag that is
// set if any intermediate or final value was clipped. Each recurrence step
// passes through the states S_LO, S_HI, S_RND and S_ADD, because the product
// of x and the guarded accumulator is formed as two narrower partial
// products in successive states before the rounding and the sum stages, so
// an evaluation holds the input for one step per term in use (a term count
// of zero acts as one, and a count above MAX_TERMS acts as MAX_TERMS), and
// its final step also waits while an earlier result is stalled at the output.
// The input is stalled while an evaluation runs; the finished result sits in
// an output register, and the next beat is accepted while it waits. The
// coefficient at index zero is added as stored, so it is expected pre-halved,
// and every coefficient in use must be loaded before the first evaluation.
// The term count register may only be written while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module chebyshev_clenshaw_eval #(
	parameter int MAX_TERMS  = cce_pkg::MAX_TERMS_DEF,
	parameter int DATA_WIDTH = cce_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = cce_pkg::FRAC_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic                         opcode,
	input  wire logic [cce_pkg::IDX_BITS-1:0] coeff_index,
	input  wire logic signed [DATA_WIDTH-1:0] coeff_value,
	input  wire logic signed [DATA_WIDTH-1:0] x_value,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic signed [DATA_WIDTH-1:0]      series_value,
	output logic                              saturated,
	input  wire logic                         cfg_we,
	input  wire logic [cce_pkg::NT_BITS-1:0]  cfg_wdata
);

	cce_pkg::cmd_t cmd;
	cce_pkg::sts_t sts;

	cce_ctrl #(
		.MAX_TERMS (MAX_TERMS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.opcode    (opcode),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.sts       (sts),
		.cmd       (cmd)
	);

	cce_dpath #(
		.MAX_TERMS  (MAX_TERMS),
		.DATA_WIDTH (DATA_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.coeff_index  (coeff_index),
		.coeff_value  (coeff_value),
		.x_value      (x_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.series_value (series_value),
		.saturated    (saturated)
	);

endmodule

`default_nettype wire
